>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers; bodies drop out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define NBL_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define NBL_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define NBL_ASSERT(lbl, clk, rst, prop)
`define NBL_ASSERT_NR(lbl, clk, prop)
`endif

`endif

>>> rtl/nbl_pkg.sv
// ---------------------------------------------------------------------------
// nbl_pkg
// Shared types, constants and bit functions for the newline bitmap block.
// ---------------------------------------------------------------------------
package nbl_pkg;

  localparam int WORD_W     = 64;
  localparam int BIT_IDX_W  = 6;
  localparam int OFF_W      = 16;
  localparam int WORD_IDX_W = OFF_W - BIT_IDX_W;
  localparam int MAX_WORDS  = 1 << WORD_IDX_W;
  localparam int NUM_W      = 17;
  localparam int CNT_W      = BIT_IDX_W + 1;

  localparam logic KIND_MARK   = 1'b0;
  localparam logic KIND_LOCATE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;      // capture the input item
    logic clr_wr;    // write a zero word at the sweep counter
    logic mark_rd;   // read the word holding the mark position
    logic mark_wr;   // write that word back with the bit set
    logic scan_rd;   // read the word at the sweep counter
    logic out_load;  // move the locate result into the output register
  } cmd_t;

  typedef struct packed {
    logic clr_last;  // counter sits on the last map word
    logic scan_last; // counter sits on the last word of this scan
    logic out_busy;  // output register full and not taken this cycle
  } status_t;

  function automatic logic [CNT_W-1:0] popcount(input logic [WORD_W-1:0] w);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < WORD_W; i++) begin
      n = n + CNT_W'(w[i]);
    end
    return n;
  endfunction

  function automatic logic [BIT_IDX_W-1:0] top_bit(input logic [WORD_W-1:0] w);
    logic [BIT_IDX_W-1:0] p;
    p = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (w[i]) begin
        p = BIT_IDX_W'(i);
      end
    end
    return p;
  endfunction

endpackage

>>> rtl/nbl_dp.sv
// ---------------------------------------------------------------------------
// nbl_dp
// Bitmap memory, sweep counter, scan accumulators and output register.
// ---------------------------------------------------------------------------
module nbl_dp import nbl_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output status_t              status,
  input  logic [OFF_W-1:0]     in_offset,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [NUM_W-1:0]     out_line,
  output logic [NUM_W-1:0]     out_col
);

  logic [WORD_W-1:0]     mem [DEPTH];
  logic [WORD_W-1:0]     rdata;
  logic [AW-1:0]         raddr;
  logic [AW-1:0]         ridx;
  logic                  rvalid;
  logic [AW-1:0]         cnt;
  logic [OFF_W-1:0]      offset;
  logic [NUM_W-1:0]      acc;
  logic                  have_mark;
  logic [OFF_W-1:0]      last_pos;
  logic [WORD_IDX_W-1:0] full;
  logic [BIT_IDX_W-1:0]  rem;
  logic                  in_map;
  logic [AW-1:0]         lim;
  logic [WORD_W-1:0]     word;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [WORD_W-1:0]     wdata;

  assign full   = offset[OFF_W-1:BIT_IDX_W];
  assign rem    = offset[BIT_IDX_W-1:0];
  assign in_map = 32'(full) < 32'(DEPTH);
  assign lim    = in_map ? AW'(full) : AW'(DEPTH - 1);

  assign status.clr_last  = cnt == AW'(DEPTH - 1);
  assign status.scan_last = cnt == lim;
  assign status.out_busy  = out_valid && !out_ready;

  // memory ports
  assign raddr = cmd.mark_rd ? AW'(full) : cnt;
  assign we    = cmd.clr_wr || (cmd.mark_wr && in_map);
  assign waddr = cmd.clr_wr ? cnt : AW'(full);
  assign wdata = cmd.clr_wr ? '0 : (rdata | (WORD_W'(1) << rem));

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd || cmd.mark_rd) begin
      rdata <= mem[raddr];
      ridx  <= raddr;
    end
  end

  // word under the scan, cut below the offset on the offset's own word
  always_comb begin
    word = rdata;
    if (WORD_IDX_W'(ridx) == full) begin
      word = rdata & ((WORD_W'(1) << rem) - WORD_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      rvalid <= 1'b0;
    end else begin
      rvalid <= cmd.scan_rd;
      if (cmd.load) begin
        cnt <= '0;
      end else if (cmd.clr_wr || cmd.scan_rd) begin
        cnt <= cnt + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      offset    <= in_offset;
      acc       <= '0;
      have_mark <= 1'b0;
    end else if (rvalid) begin
      acc <= acc + NUM_W'(popcount(word));
      if (word != '0) begin
        have_mark <= 1'b1;
        last_pos  <= {WORD_IDX_W'(ridx), top_bit(word)};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_line <= acc + NUM_W'(1);
      out_col  <= have_mark ? (NUM_W'(offset) - NUM_W'(last_pos))
                            : (NUM_W'(offset) + NUM_W'(1));
    end
  end

endmodule

>>> rtl/nbl_ctrl.sv
// ---------------------------------------------------------------------------
// nbl_ctrl
// Sequencer: clearing pass, mark read-modify-write, locate scan.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module nbl_ctrl import nbl_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_kind,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (status.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = (in_kind == KIND_LOCATE) ? ST_SCAN : ST_MARK_RD;
        end
      end
      ST_MARK_RD: begin
        cmd.mark_rd = 1'b1;
        state_next  = ST_MARK_WR;
      end
      ST_MARK_WR: begin
        cmd.mark_wr = 1'b1;
        state_next  = ST_IDLE;
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (status.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `NBL_ASSERT(a_clear_ends, clk, rst, (state == ST_CLEAR && status.clr_last) |=> state == ST_IDLE)
  `NBL_ASSERT(a_no_overwrite, clk, rst, cmd.out_load |-> !status.out_busy)
  `NBL_ASSERT(a_mark_rmw, clk, rst, cmd.mark_rd |=> cmd.mark_wr)
  `NBL_ASSERT(a_scan_drains, clk, rst, (cmd.scan_rd && status.scan_last) |=> state == ST_DRAIN)

endmodule

>>> rtl/newline_bitmap_line_column_top.sv
// ---------------------------------------------------------------------------
// newline_bitmap_line_column_top
// Newline bitmap with line and column lookup at a code-point offset.
// ---------------------------------------------------------------------------
//
//  channel  | dir | tdata                          | tuser
//  ---------+-----+--------------------------------+---------------------
//  s_axis   | in  | [15:0] offset                  | [0] kind (0 mark, 1 locate)
//  m_axis   | out | [16:0] line, [33:17] column    | -
//
//  After rst, a clearing pass zeroes the bitmap, one word a cycle, with
//  s_tready low throughout.
//  Mark: transfer, word read, word write back; no result.
//  Locate: one bitmap word is read per cycle through the single read
//  port, from word 0 up to min(offset/64, MAP_WORDS-1), popcounted and
//  searched for its top set bit on the way.
//  A finished result sits in the output register; a mark may be taken
//  while it waits, the next locate holds in its final state until the
//  register frees.
//
module newline_bitmap_line_column_top import nbl_pkg::*; #(
  parameter int MAP_WORDS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] offset
  input  logic        s_tuser,   // [0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // [16:0] line_number, [33:17] column_number
);

  // offsets reach word 1023 at most, so deeper maps add nothing
  localparam int DEPTH = (MAP_WORDS < MAX_WORDS) ? MAP_WORDS : MAX_WORDS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t             cmd;
  status_t          status;
  logic [NUM_W-1:0] line_number;
  logic [NUM_W-1:0] column_number;

  nbl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_kind  (s_tuser),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  nbl_dp #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_offset (s_tdata),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_line  (line_number),
    .out_col   (column_number)
  );

  assign m_tdata = {6'b0, column_number, line_number};

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Checks the newline bitmap line/column block against a behavioral bitmap
// kept in the bench. Mark and locate transfers go in with random gaps, and
// results are taken with random stalls. Each locate result is compared with
// the line and column worked out from the bench's own bitmap at the moment
// the locate was accepted.
// ---------------------------------------------------------------------------
module testbench;
  import nbl_pkg::*;

  localparam int MAP_WORDS  = 1024;
  localparam int CYCLE_CAP  = 1_500_000;  // watchdog limit for the whole run
  localparam int TAIL_WAIT  = 20;         // lets the last mark settle
  localparam int RAND_ITEMS = 275;

  typedef struct packed {
    logic             kind;
    logic [OFF_W-1:0] offset;
  } source_item_t;

  typedef struct packed {
    logic [NUM_W-1:0] line_number;
    logic [NUM_W-1:0] column_number;
  } line_column_t;

  // DUT ports; every input starts at a known value
  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;   // [15:0] offset
  logic        s_tuser  = 1'b0; // [0] kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;         // [16:0] line_number, [33:17] column_number

  // bench bitmap, one bit per code-point position
  logic [WORD_W-1:0] shadow_bits [MAP_WORDS];

  source_item_t pending_items[$];
  line_column_t expected_positions[$];

  source_item_t cur_item;
  logic         holding    = 1'b0;  // driver is presenting cur_item
  int           send_gap   = 0;
  int           send_calm  = 0;
  int           recv_stall = 0;
  int           recv_calm  = 0;
  int           mismatches = 0;
  int           cycle_count = 0;

  newline_bitmap_line_column_top #(
    .MAP_WORDS(MAP_WORDS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Random idle gap before the next transfer, with runs of no idling.
  function automatic int draw_gap(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  function automatic logic [WORD_W-1:0] map_word(input int idx);
    if (idx < MAP_WORDS) begin
      return shadow_bits[idx];
    end
    return '0;
  endfunction

  function automatic logic [BIT_IDX_W-1:0] highest_mark(input logic [WORD_W-1:0] w);
    logic [BIT_IDX_W-1:0] pos;
    pos = '0;
    for (int b = 0; b < WORD_W; b++) begin
      if (w[b]) begin
        pos = BIT_IDX_W'(b);
      end
    end
    return pos;
  endfunction

  // Apply one accepted transfer to the bench bitmap; a locate queues its answer.
  function automatic void track_newlines(input source_item_t it);
    int                full;
    int                rem;
    int                w;
    logic              found;
    logic [WORD_W-1:0] part;
    line_column_t      res;
    full = int'(it.offset) / WORD_W;
    rem  = int'(it.offset) % WORD_W;
    if (it.kind == KIND_MARK) begin
      // marks past the map are dropped; setting a set bit is harmless
      if (full < MAP_WORDS) begin
        shadow_bits[full][rem] = 1'b1;
      end
      return;
    end
    res.line_number   = NUM_W'(1);
    res.column_number = NUM_W'(it.offset) + NUM_W'(1);
    for (w = 0; w < full; w++) begin
      res.line_number += NUM_W'($countones(map_word(w)));
    end
    part = map_word(full) & ((WORD_W'(1) << rem) - WORD_W'(1));
    res.line_number += NUM_W'($countones(part));
    if (part != '0) begin
      res.column_number = NUM_W'(it.offset)
                        - NUM_W'(full * WORD_W + int'(highest_mark(part)));
    end else begin
      // nearest earlier mark sits in some lower word, if anywhere
      found = 1'b0;
      for (w = full - 1; w >= 0 && !found; w--) begin
        if (map_word(w) != '0) begin
          found = 1'b1;
          res.column_number = NUM_W'(it.offset)
                            - NUM_W'(w * WORD_W + int'(highest_mark(map_word(w))));
        end
      end
    end
    expected_positions.push_back(res);
  endfunction

  // Source side: present queued items, idle a random number of cycles between.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      holding  = 1'b0;
      send_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        track_newlines(cur_item);
        holding  = 1'b0;
        send_gap = draw_gap(send_calm);
      end
      if (!holding) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          holding  = 1'b1;
        end
      end
      s_tvalid <= holding;
      if (holding) begin
        s_tdata <= cur_item.offset;
        s_tuser <= cur_item.kind;
      end
    end
  end

  // Result side: random stalls on tready, compare each transfer in order.
  always @(posedge clk) begin
    line_column_t exp_pos;
    if (rst) begin
      m_tready   <= 1'b0;
      recv_stall = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_positions.size() == 0) begin
          $error("unexpected result: line %0d column %0d",
                 m_tdata[16:0], m_tdata[33:17]);
          mismatches++;
        end else begin
          exp_pos = expected_positions.pop_front();
          if (m_tdata[16:0] !== exp_pos.line_number) begin
            $error("line_number: expected %0d, got %0d",
                   exp_pos.line_number, m_tdata[16:0]);
            mismatches++;
          end
          if (m_tdata[33:17] !== exp_pos.column_number) begin
            $error("column_number: expected %0d, got %0d",
                   exp_pos.column_number, m_tdata[33:17]);
            mismatches++;
          end
        end
        recv_stall = draw_gap(recv_calm);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog; also covers the clearing pass after reset.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("newline_bitmap_line_column_top: mismatch");
      $finish;
    end
  end

  task automatic add_item(input logic kind, input int off);
    source_item_t it;
    it.kind   = kind;
    it.offset = OFF_W'(off);
    pending_items.push_back(it);
  endtask

  initial begin
    int last_mark;
    int off;
    int sel;
    for (int w = 0; w < MAP_WORDS; w++) begin
      shadow_bits[w] = '0;
    end

    // Directed: empty map, both ends of the offset range
    add_item(KIND_LOCATE, 0);       // line 1, column 1
    add_item(KIND_LOCATE, 65535);   // no marks: column is offset + 1
    // mark at 0; a mark at the offset itself does not count
    add_item(KIND_MARK, 0);
    add_item(KIND_LOCATE, 0);
    add_item(KIND_LOCATE, 1);
    add_item(KIND_MARK, 0);         // repeated mark changes nothing
    add_item(KIND_LOCATE, 1);
    // word boundary at 63/64
    add_item(KIND_MARK, 63);
    add_item(KIND_MARK, 64);
    add_item(KIND_LOCATE, 63);
    add_item(KIND_LOCATE, 64);
    add_item(KIND_LOCATE, 65);
    // nearest mark several words back
    add_item(KIND_LOCATE, 1000);
    // far marks; 65535 mark is never strictly before any offset
    add_item(KIND_MARK, 32768);
    add_item(KIND_LOCATE, 40000);
    add_item(KIND_MARK, 65535);
    add_item(KIND_LOCATE, 65535);
    add_item(KIND_MARK, 65472);
    add_item(KIND_LOCATE, 65535);
    add_item(KIND_LOCATE, 32769);

    // Random part: mostly low offsets to keep locates short and the map dense
    // there, some anywhere, some right around a recent mark.
    last_mark = 64;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
        off = $urandom_range(0, 2047);
      end else if (sel < 9) begin
        off = $urandom_range(0, 65535);
      end else begin
        off = last_mark + $urandom_range(0, 4) - 2;
        if (off < 0) off = 0;
        if (off > 65535) off = 65535;
      end
      if ($urandom_range(0, 99) < 45) begin
        add_item(KIND_MARK, off);
        last_mark = off;
      end else begin
        add_item(KIND_LOCATE, off);
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // drain: everything sent, every locate answered, last mark settled
    while (pending_items.size() > 0 || holding || expected_positions.size() > 0) begin
      @(posedge clk);
    end
    repeat (TAIL_WAIT) @(posedge clk);

    if (mismatches == 0) begin
      $display("newline_bitmap_line_column_top: match");
    end else begin
      $display("newline_bitmap_line_column_top: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/nbl_pkg.sv
rtl/nbl_dp.sv
rtl/nbl_ctrl.sv
rtl/newline_bitmap_line_column_top.sv
test/testbench.sv
